### sv/dht11_reader_with_relay_control_top_macros.svh
// Assertion macros for the RTL files; dhtr_queue is the one that uses them.
`ifndef DHT11_READER_WITH_RELAY_CONTROL_TOP_MACROS_SVH
`define DHT11_READER_WITH_RELAY_CONTROL_TOP_MACROS_SVH

// Checked at every edge, quiet while reset is high.
`define DHTR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define DHTR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/dhtr_pkg.sv
`default_nettype none
package dhtr_pkg;

   localparam logic [6:0] MAX_CHANGES  = 7'd85;
   localparam logic [5:0] FRAME_BITS   = 6'd40;
   localparam logic [6:0] FIRST_BIT_CH = 7'd4;
   localparam int         QUEUE_DEPTH  = 2;

   // register indexes, byte address 4*index
   localparam logic [2:0] REG_BIT_THRESHOLD    = 3'd0;
   localparam logic [2:0] REG_TIMEOUT_COUNT    = 3'd1;
   localparam logic [2:0] REG_TEMP_LIMIT       = 3'd2;
   localparam logic [2:0] REG_HUMID_LIMIT      = 3'd3;
   localparam logic [2:0] REG_HEATER_AUTO      = 3'd4;
   localparam logic [2:0] REG_HEATER_MANUAL_ON = 3'd5;
   localparam logic [2:0] REG_FAN_AUTO         = 3'd6;
   localparam logic [2:0] REG_FAN_MANUAL_ON    = 3'd7;

   typedef struct packed {
      logic [7:0] bit_threshold;
      logic [7:0] timeout_count;
      logic [8:0] temp_limit;
      logic [8:0] humid_limit;
      logic       heater_auto;
      logic       heater_manual_on;
      logic       fan_auto;
      logic       fan_manual_on;
   } dhtr_cfg_type;

   // one finished read, handed from front to back
   typedef struct packed {
      logic [4:0][7:0] frame;
      logic            full;
      logic            timed;
   } dhtr_rec_type;

   // x/10 for 8-bit x: (x*205)>>11 is exact below 1029
   function automatic logic [7:0] div10(input logic [7:0] x);
      logic [15:0] p;
      p = {8'd0, x} * 16'd205;
      return {3'd0, p[15:11]};
   endfunction

endpackage
`default_nettype wire

### sv/dhtr_front.sv
`default_nettype none
module dhtr_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dhtr_pkg::dhtr_cfg_type cfg,
   input  wire logic                  beat,
   input  wire logic                  op_start,
   input  wire logic                  pin,
   output logic                       push,
   output dhtr_pkg::dhtr_rec_type     rec
);
   import dhtr_pkg::*;

   logic            last_level_ff, last_level_in;
   logic [7:0]      level_count_ff, level_count_in;
   logic [6:0]      change_index_ff, change_index_in;
   logic [5:0]      bits_taken_ff, bits_taken_in;
   logic [4:0][7:0] frame_ff, frame_in;
   logic            read_active_ff, read_active_in;
   logic            push_in, timed_in;

   always_comb begin
      logic [2:0] k;
      last_level_in   = last_level_ff;
      level_count_in  = level_count_ff;
      change_index_in = change_index_ff;
      bits_taken_in   = bits_taken_ff;
      frame_in        = frame_ff;
      read_active_in  = read_active_ff;
      push_in         = 1'b0;
      timed_in        = 1'b0;
      k               = bits_taken_ff[5:3];
      if (beat) begin
         if (op_start) begin
            level_count_in  = 8'd0;
            change_index_in = 7'd0;
            bits_taken_in   = 6'd0;
            frame_in        = '0;
            read_active_in  = 1'b1;
         end else if (read_active_ff) begin
            if (pin == last_level_ff) begin
               level_count_in = level_count_ff + 8'd1;
               if (level_count_in == cfg.timeout_count) begin
                  push_in  = 1'b1;
                  timed_in = 1'b1;
               end
            end else begin
               last_level_in = pin;
               if (change_index_ff >= FIRST_BIT_CH && !change_index_ff[0] &&
                   bits_taken_ff < FRAME_BITS) begin
                  frame_in[k]   = {frame_ff[k][6:0], level_count_ff > cfg.bit_threshold};
                  bits_taken_in = bits_taken_ff + 6'd1;
               end
               change_index_in = change_index_ff + 7'd1;
               if (change_index_in >= MAX_CHANGES) begin
                  push_in = 1'b1;
               end else begin
                  level_count_in = 8'd1;
                  if (cfg.timeout_count == 8'd1) begin
                     push_in  = 1'b1;
                     timed_in = 1'b1;
                  end
               end
            end
            if (push_in) read_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff   <= 1'b1;
         level_count_ff  <= 8'd0;
         change_index_ff <= 7'd0;
         bits_taken_ff   <= 6'd0;
         frame_ff        <= '0;
         read_active_ff  <= 1'b0;
      end else begin
         last_level_ff   <= last_level_in;
         level_count_ff  <= level_count_in;
         change_index_ff <= change_index_in;
         bits_taken_ff   <= bits_taken_in;
         frame_ff        <= frame_in;
         read_active_ff  <= read_active_in;
      end
   end

   assign push      = push_in;
   assign rec.frame = frame_in;
   assign rec.full  = (bits_taken_in >= FRAME_BITS);
   assign rec.timed = timed_in;

endmodule
`default_nettype wire

### sv/dhtr_queue.sv
`default_nettype none
`include "dht11_reader_with_relay_control_top_macros.svh"
module dhtr_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire dhtr_pkg::dhtr_rec_type push_rec,
   output logic                        full,
   input  wire logic                   pop,
   output logic                        head_valid,
   output dhtr_pkg::dhtr_rec_type      head_rec
);
   import dhtr_pkg::*;

   dhtr_rec_type entry_ff [QUEUE_DEPTH];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = ~wr_ptr_ff;
      if (pop)  rd_ptr_in = ~rd_ptr_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_rec;
   end

   assign full       = (count_ff == 2'(QUEUE_DEPTH));
   assign head_valid = (count_ff != 2'd0);
   assign head_rec   = entry_ff[rd_ptr_ff];

   `DHTR_ASSERT(a_no_push_when_full, clock, reset, !(push && full), "push into full queue")
   `DHTR_ASSERT(a_count_in_range, clock, reset, count_ff <= 2'(QUEUE_DEPTH), "queue count overrun")
   `DHTR_ASSERT(a_ptrs_track_count, clock, reset,
      (count_ff == 2'd1) == (wr_ptr_ff != rd_ptr_ff), "queue pointers disagree with count")
   `DHTR_ASSERT(a_push_lands, clock, reset, (push && !pop) |=> head_valid, "pushed record lost")

endmodule
`default_nettype wire

### sv/dhtr_back.sv
`default_nettype none
module dhtr_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dhtr_pkg::dhtr_cfg_type cfg,
   input  wire logic                   head_valid,
   input  wire dhtr_pkg::dhtr_rec_type head_rec,
   output logic                        pop,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output logic [23:0]                 out_data
);
   import dhtr_pkg::*;

   logic        temp_ff, unused_ff;
   logic [8:0]  temp_store_ff, temp_store_in;
   logic [8:0]  humid_store_ff, humid_store_in;
   logic        valid_ff;
   logic [21:0] data_ff, data_in;
   logic [7:0]  sum;
   logic        ok, heater, fan;

   assign pop = head_valid && (!valid_ff || out_ready);

   always_comb begin
      sum = head_rec.frame[0] + head_rec.frame[1] + head_rec.frame[2] + head_rec.frame[3];
      ok  = head_rec.full && (head_rec.frame[4] == sum);
      temp_store_in  = temp_store_ff;
      humid_store_in = humid_store_ff;
      if (ok) begin
         temp_store_in  = {1'b0, head_rec.frame[2]} + {1'b0, div10(head_rec.frame[3])};
         humid_store_in = {1'b0, head_rec.frame[0]} + {1'b0, div10(head_rec.frame[1])};
      end
      heater  = cfg.heater_auto ? (temp_store_in > cfg.temp_limit) : cfg.heater_manual_on;
      fan     = cfg.fan_auto ? (humid_store_in > cfg.humid_limit) : cfg.fan_manual_on;
      data_in = {fan, heater, humid_store_in, temp_store_in, head_rec.timed, ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_store_ff  <= 9'd0;
         humid_store_ff <= 9'd0;
         valid_ff       <= 1'b0;
      end else begin
         if (pop) begin
            temp_store_ff  <= temp_store_in;
            humid_store_ff <= humid_store_in;
            valid_ff       <= 1'b1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = {2'b00, data_ff};

endmodule
`default_nettype wire

### sv/dht11_reader_with_relay_control_top.sv
// A read-ending beat's record is written to the record queue, then to the result register.
// One beat per cycle unless the queue is full; the per-tick step is combinational.
// A two-entry record queue parts the front from the result register, so each stalls alone.
// Reset (synchronous, active high) restores register defaults, line level high, no read.
// Stored temperature and humidity clear to zero on reset.
`default_nettype none
module dht11_reader_with_relay_control_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [0] pin_level
   input  wire logic        req_tuser,   // [0] operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [0] data_ok [1] timed_out [10:2] temp_value
                                         // [19:11] humid_value [20] heater_on [21] fan_on
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import dhtr_pkg::*;

   dhtr_cfg_type cfg_ff;
   dhtr_rec_type push_rec, head_rec;
   logic         push, q_full, pop, head_valid, beat, csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_threshold    <= 8'd16;
         cfg_ff.timeout_count    <= 8'd255;
         cfg_ff.temp_limit       <= 9'd25;
         cfg_ff.humid_limit      <= 9'd25;
         cfg_ff.heater_auto      <= 1'b0;
         cfg_ff.heater_manual_on <= 1'b0;
         cfg_ff.fan_auto         <= 1'b0;
         cfg_ff.fan_manual_on    <= 1'b0;
      end else if (csr_wr) begin
         case (csr_paddr[4:2])
            REG_BIT_THRESHOLD:    cfg_ff.bit_threshold    <= csr_pwdata[7:0];
            REG_TIMEOUT_COUNT:    cfg_ff.timeout_count    <= csr_pwdata[7:0];
            REG_TEMP_LIMIT:       cfg_ff.temp_limit       <= csr_pwdata[8:0];
            REG_HUMID_LIMIT:      cfg_ff.humid_limit      <= csr_pwdata[8:0];
            REG_HEATER_AUTO:      cfg_ff.heater_auto      <= csr_pwdata[0];
            REG_HEATER_MANUAL_ON: cfg_ff.heater_manual_on <= csr_pwdata[0];
            REG_FAN_AUTO:         cfg_ff.fan_auto         <= csr_pwdata[0];
            REG_FAN_MANUAL_ON:    cfg_ff.fan_manual_on    <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_BIT_THRESHOLD:    csr_prdata = {24'd0, cfg_ff.bit_threshold};
         REG_TIMEOUT_COUNT:    csr_prdata = {24'd0, cfg_ff.timeout_count};
         REG_TEMP_LIMIT:       csr_prdata = {23'd0, cfg_ff.temp_limit};
         REG_HUMID_LIMIT:      csr_prdata = {23'd0, cfg_ff.humid_limit};
         REG_HEATER_AUTO:      csr_prdata = {31'd0, cfg_ff.heater_auto};
         REG_HEATER_MANUAL_ON: csr_prdata = {31'd0, cfg_ff.heater_manual_on};
         REG_FAN_AUTO:         csr_prdata = {31'd0, cfg_ff.fan_auto};
         REG_FAN_MANUAL_ON:    csr_prdata = {31'd0, cfg_ff.fan_manual_on};
         default:              csr_prdata = 32'd0;
      endcase
   end

   assign req_tready = !q_full;
   assign beat       = req_tvalid && req_tready;

   dhtr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .beat     (beat),
      .op_start (req_tuser),
      .pin      (req_tdata[0]),
      .push     (push),
      .rec      (push_rec)
   );

   dhtr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_rec   (push_rec),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_rec   (head_rec)
   );

   dhtr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_rec   (head_rec),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (rsp_tdata)
   );

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
   import dhtr_pkg::*;

   localparam logic OP_SAMPLE     = 1'b0;
   localparam logic OP_START      = 1'b1;
   localparam int   SETTLE_CYCLES = 12;
   localparam int   RANDOM_BEATS  = 1850;
   localparam int   RANDOM_READS  = 36;
   localparam int   DRAIN_LIMIT   = 5000;

   typedef logic [4:0][7:0] frame_t;

   typedef struct packed {
      logic       data_ok;
      logic       timed_out;
      logic [8:0] temp_value;
      logic [8:0] humid_value;
      logic       heater_on;
      logic       fan_on;
   } read_result_t;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic [7:0]  req_tdata   = 8'd0;   // [0] pin_level
   logic        req_tuser   = 1'b0;   // [0] operation
   logic        rsp_tready  = 1'b0;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [4:0]  csr_paddr   = 5'd0;
   logic [31:0] csr_pwdata  = 32'd0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [23:0] rsp_tdata;            // [0] data_ok [1] timed_out [10:2] temp_value
                                      // [19:11] humid_value [20] heater_on [21] fan_on
   logic [31:0] csr_prdata;
   logic        csr_pready;

   dht11_reader_with_relay_control_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // sensor decoder model state
   dhtr_cfg_type cfg;
   logic         line_level;
   logic [7:0]   run_length;
   logic [6:0]   edge_count;
   logic [5:0]   bits_in;
   logic [7:0]   frame [5];
   logic         reading;
   logic [8:0]   temp_held;
   logic [8:0]   humid_held;
   read_result_t pending_reads [$];

   int send_idle_pct = 37;
   int recv_idle_pct = 77;
   int hold_request  = 0;
   int hold_left     = 0;
   int errors        = 0;
   int reads_checked = 0;
   int beats_sent    = 0;
   int live_beats    = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("tb_top failed");
      $finish;
   end

   function automatic void model_reset();
      cfg.bit_threshold    = 8'd16;
      cfg.timeout_count    = 8'd255;
      cfg.temp_limit       = 9'd25;
      cfg.humid_limit      = 9'd25;
      cfg.heater_auto      = 1'b0;
      cfg.heater_manual_on = 1'b0;
      cfg.fan_auto         = 1'b0;
      cfg.fan_manual_on    = 1'b0;
      line_level = 1'b1;
      run_length = '0;
      edge_count = '0;
      bits_in    = '0;
      foreach (frame[i]) frame[i] = '0;
      reading    = 1'b0;
      temp_held  = '0;
      humid_held = '0;
   endfunction

   function automatic void close_read(input logic timed);
      logic [7:0]   sum;
      read_result_t r;
      sum = frame[0] + frame[1] + frame[2] + frame[3];
      r.data_ok = (bits_in >= FRAME_BITS) && (frame[4] == sum);
      if (r.data_ok) begin
         temp_held  = {1'b0, frame[2]} + frame[3] / 10;
         humid_held = {1'b0, frame[0]} + frame[1] / 10;
      end
      reading       = 1'b0;
      r.timed_out   = timed;
      r.temp_value  = temp_held;
      r.humid_value = humid_held;
      r.heater_on   = cfg.heater_auto ? (temp_held > cfg.temp_limit) : cfg.heater_manual_on;
      r.fan_on      = cfg.fan_auto ? (humid_held > cfg.humid_limit) : cfg.fan_manual_on;
      pending_reads.push_back(r);
   endfunction

   function automatic void sensor_step(input logic op, input logic pin);
      logic [2:0] k;
      if (op == OP_START) begin
         foreach (frame[i]) frame[i] = '0;
         run_length = '0;
         edge_count = '0;
         bits_in    = '0;
         reading    = 1'b1;
         return;
      end
      if (!reading) return;
      if (pin == line_level) begin
         run_length = run_length + 8'd1;
         if (run_length == cfg.timeout_count) close_read(1'b1);
         return;
      end
      line_level = pin;
      // bits sit on the odd-numbered edges from the fifth on; the ended level's length decides
      if (edge_count >= FIRST_BIT_CH && !edge_count[0] && bits_in < FRAME_BITS) begin
         k = bits_in[5:3];
         frame[k] = {frame[k][6:0], run_length > cfg.bit_threshold};
         bits_in = bits_in + 6'd1;
      end
      edge_count = edge_count + 7'd1;
      if (edge_count >= MAX_CHANGES) begin
         close_read(1'b0);
         return;
      end
      // the tick showing the new level is its first
      run_length = 8'd1;
      if (run_length == cfg.timeout_count) close_read(1'b1);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
               reads_checked);
      errors++;
   endtask

   task automatic check_field(input string what, input int got, input int want);
      if (got != want) report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin : rsp_check
      read_result_t got;
      read_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.data_ok     = rsp_tdata[0];
         got.timed_out   = rsp_tdata[1];
         got.temp_value  = rsp_tdata[10:2];
         got.humid_value = rsp_tdata[19:11];
         got.heater_on   = rsp_tdata[20];
         got.fan_on      = rsp_tdata[21];
         if (pending_reads.size() == 0) begin
            report_mismatch("result beat with no read pending", 1, 0);
         end else begin
            want = pending_reads.pop_front();
            check_field("data_ok", got.data_ok, want.data_ok);
            check_field("timed_out", got.timed_out, want.timed_out);
            check_field("temp_value", got.temp_value, want.temp_value);
            check_field("humid_value", got.humid_value, want.humid_value);
            check_field("heater_on", got.heater_on, want.heater_on);
            check_field("fan_on", got.fan_on, want.fan_on);
         end
         reads_checked++;
      end
   end

   // result side: random stalls, plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_beat(input logic op, input logic pin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, pin};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_START || reading) live_beats++;
      beats_sent++;
      sensor_step(op, pin);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_config(input dhtr_cfg_type c);
      settle();
      write_reg(REG_BIT_THRESHOLD,    {24'd0, c.bit_threshold});
      write_reg(REG_TIMEOUT_COUNT,    {24'd0, c.timeout_count});
      write_reg(REG_TEMP_LIMIT,       {23'd0, c.temp_limit});
      write_reg(REG_HUMID_LIMIT,      {23'd0, c.humid_limit});
      write_reg(REG_HEATER_AUTO,      {31'd0, c.heater_auto});
      write_reg(REG_HEATER_MANUAL_ON, {31'd0, c.heater_manual_on});
      write_reg(REG_FAN_AUTO,         {31'd0, c.fan_auto});
      write_reg(REG_FAN_MANUAL_ON,    {31'd0, c.fan_manual_on});
      cfg = c;
   endtask

   function automatic frame_t frame_of(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] b2, input logic [7:0] b3,
                                       input logic good);
      frame_t f;
      f[0] = b0;
      f[1] = b1;
      f[2] = b2;
      f[3] = b3;
      f[4] = b0 + b1 + b2 + b3;
      if (!good) f[4] = f[4] ^ (8'd1 << $urandom_range(7));
      return f;
   endfunction

   function automatic frame_t random_frame(input logic good);
      return frame_of($urandom_range(255), $urandom_range(255), $urandom_range(255),
                      $urandom_range(255), good);
   endfunction

   // start, then line edges 0..stop_at-1 of a sensor frame; optionally hold to timeout
   task automatic send_frame(input frame_t f, input int stop_at, input bit hold);
      int   thr;
      int   len;
      int   bit_no;
      logic lvl;
      thr = cfg.bit_threshold;
      send_beat(OP_START, $urandom_range(1));
      repeat ($urandom_range(2)) send_beat(OP_SAMPLE, line_level);
      for (int j = 0; j < stop_at && j < MAX_CHANGES && reading; j++) begin
         lvl = !line_level;
         if (j == MAX_CHANGES - 1) begin
            len = 1;
         end else if (j % 2 == 1 && j >= 3 && j <= 81) begin
            bit_no = (j - 3) / 2;
            if (f[bit_no / 8][7 - bit_no % 8]) begin
               len = thr + 1 + $urandom_range(2);
               if (len > 255) len = 255;
            end else if (thr == 0) begin
               len = 1;
            end else if (thr > 4 && $urandom_range(7) == 0) begin
               len = thr;
            end else begin
               len = $urandom_range(1, (thr < 4) ? thr : 4);
            end
         end else begin
            len = $urandom_range(1, 3);
         end
         send_beat(OP_SAMPLE, lvl);
         for (int n = 1; n < len && reading; n++) send_beat(OP_SAMPLE, lvl);
      end
      if (hold) while (reading) send_beat(OP_SAMPLE, line_level);
   endtask

   task automatic send_noise(input int runs);
      logic lvl;
      send_beat(OP_START, $urandom_range(1));
      for (int r = 0; r < runs; r++) begin
         lvl = $urandom_range(1);
         if ($urandom_range(15) == 0) send_beat(OP_START, lvl);
         else repeat ($urandom_range(1, cfg.timeout_count + 1)) send_beat(OP_SAMPLE, lvl);
      end
      while (reading) send_beat(OP_SAMPLE, line_level);
   endtask

   function automatic logic [8:0] random_limit();
      if ($urandom_range(3) == 0) return $urandom_range(1) ? 9'd300 : 9'd0;
      return $urandom_range(300);
   endfunction

   function automatic dhtr_cfg_type random_cfg();
      dhtr_cfg_type c;
      c.bit_threshold    = $urandom_range(3);
      c.timeout_count    = c.bit_threshold + $urandom_range(4, 9);
      c.temp_limit       = random_limit();
      c.humid_limit      = random_limit();
      c.heater_auto      = $urandom_range(1);
      c.heater_manual_on = $urandom_range(1);
      c.fan_auto         = $urandom_range(1);
      c.fan_manual_on    = $urandom_range(1);
      return c;
   endfunction

   task automatic test_idle_ticks();
      // no read active: ignored, no result
      send_beat(OP_SAMPLE, 1'b0);
      send_beat(OP_SAMPLE, 1'b1);
      send_beat(OP_SAMPLE, 1'b0);
   endtask

   task automatic test_reset_config_frame();
      send_frame(frame_of(8'd55, 8'd5, 8'd24, 8'd7, 1'b1), MAX_CHANGES, 1'b1);
   endtask

   task automatic test_timeout_edges();
      dhtr_cfg_type c;
      c = cfg;
      c.timeout_count    = 8'd1;
      c.heater_manual_on = 1'b1;
      c.fan_manual_on    = 1'b1;
      apply_config(c);
      send_beat(OP_START, 1'b0);
      send_beat(OP_SAMPLE, line_level);
      // a change tick already counts one
      send_beat(OP_START, 1'b1);
      send_beat(OP_SAMPLE, !line_level);
      // zero limit is met only when the 8-bit count wraps
      c.timeout_count = 8'd0;
      apply_config(c);
      send_beat(OP_START, 1'b0);
      while (reading) send_beat(OP_SAMPLE, line_level);
   endtask

   task automatic test_value_extremes();
      dhtr_cfg_type c;
      c.bit_threshold    = 8'd2;
      c.timeout_count    = 8'd8;
      c.temp_limit       = 9'd0;
      c.humid_limit      = 9'd0;
      c.heater_auto      = 1'b1;
      c.heater_manual_on = 1'b0;
      c.fan_auto         = 1'b1;
      c.fan_manual_on    = 1'b0;
      apply_config(c);
      send_frame(frame_of(8'd255, 8'd255, 8'd255, 8'd255, 1'b1), MAX_CHANGES, 1'b1);
      c.temp_limit  = 9'd300;
      c.humid_limit = 9'd300;
      apply_config(c);
      send_frame(random_frame(1'b1), 3, 1'b1);
      c.temp_limit  = 9'd279;
      c.humid_limit = 9'd280;
      apply_config(c);
      send_frame(random_frame(1'b1), 3, 1'b1);
      c.temp_limit  = 9'd0;
      c.humid_limit = 9'd0;
      apply_config(c);
      send_frame(frame_of(8'd0, 8'd0, 8'd0, 8'd0, 1'b1), MAX_CHANGES, 1'b1);
   endtask

   task automatic test_check_failures();
      dhtr_cfg_type c;
      c = cfg;
      c.bit_threshold = 8'd3;
      c.timeout_count = 8'd9;
      c.heater_auto   = 1'b0;
      c.fan_auto      = 1'b0;
      apply_config(c);
      send_frame(random_frame(1'b0), MAX_CHANGES, 1'b1);
      // every level exceeds a zero threshold: all ones, sum cannot match
      c.bit_threshold = 8'd0;
      apply_config(c);
      send_frame(random_frame(1'b1), MAX_CHANGES, 1'b1);
      c.bit_threshold = 8'd254;
      c.timeout_count = 8'd0;
      apply_config(c);
      send_frame(frame_of(8'd0, 8'd0, 8'd1, 8'd0, 1'b1), MAX_CHANGES, 1'b1);
   endtask

   task automatic test_partial_reads();
      dhtr_cfg_type c;
      c = cfg;
      c.bit_threshold = 8'd2;
      c.timeout_count = 8'd7;
      apply_config(c);
      send_frame(random_frame(1'b1), 40, 1'b1);
      // all forty bits in, then timeout before the last edge
      send_frame(random_frame(1'b1), MAX_CHANGES - 1, 1'b1);
      // restart in the middle of a frame
      send_frame(random_frame(1'b1), 30, 1'b0);
      send_frame(random_frame(1'b1), MAX_CHANGES, 1'b1);
   endtask

   task automatic test_backpressure();
      dhtr_cfg_type c;
      int           saved_pct;
      c = cfg;
      c.timeout_count = 8'd1;
      apply_config(c);
      saved_pct = send_idle_pct;
      send_idle_pct = 0;
      hold_request = 150;
      repeat (40) begin
         send_beat(OP_START, $urandom_range(1));
         send_beat(OP_SAMPLE, $urandom_range(1));
      end
      send_idle_pct = saved_pct;
      settle();
   endtask

   task automatic random_read();
      int k;
      k = $urandom_range(99);
      repeat ($urandom_range(1)) send_beat(OP_SAMPLE, $urandom_range(1));
      if (k < 45) begin
         send_frame(random_frame($urandom_range(4) != 0), MAX_CHANGES, 1'b1);
      end else if (k < 70) begin
         send_frame(random_frame(1'b1), $urandom_range(84), 1'b1);
      end else if (k < 80) begin
         send_frame(random_frame(1'b1), $urandom_range(1, 60), 1'b0);
         send_frame(random_frame(1'b1), MAX_CHANGES, 1'b1);
      end else begin
         send_noise($urandom_range(5, 30));
      end
   endtask

   task automatic test_random();
      int first_beat;
      int first_read;
      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 37 : (mode == 1) ? 77 : 0;
         recv_idle_pct = (mode == 0) ? 77 : (mode == 1) ? 37 : 0;
         first_beat = live_beats;
         first_read = reads_checked;
         while (live_beats - first_beat < RANDOM_BEATS / 3 ||
                reads_checked - first_read < RANDOM_READS / 3) begin
            apply_config(random_cfg());
            repeat (4) random_read();
         end
      end
   endtask

   initial begin
      model_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_ticks();
      test_reset_config_frame();
      test_timeout_edges();
      test_value_extremes();
      test_check_failures();
      test_partial_reads();
      test_backpressure();
      test_random();
      req_tvalid <= 1'b0;
      for (int n = 0; n < DRAIN_LIMIT && pending_reads.size() != 0; n++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_reads.size() != 0)
         report_mismatch("reads left unanswered", 0, pending_reads.size());
      $display("Checked %0d sensor reads from %0d beats (%0d ignored idle ticks),",
               reads_checked, beats_sent, beats_sent - live_beats);
      $display("over varied thresholds, timeouts and relay modes, with stalls on both sides.");
      if (errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

### files.f
+incdir+sv
sv/dhtr_pkg.sv
sv/dhtr_front.sv
sv/dhtr_queue.sv
sv/dhtr_back.sv
sv/dht11_reader_with_relay_control_top.sv
tb/tb_top.sv
